/* src/deq_pkg.sv */
// shared constants for the double-ended queue: request and status codes,
// fixed port widths and parameter defaults; no dependencies
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int REQ_W       = 4;
    localparam int INDEX_W     = 4;
    localparam int PORT_DATA_W = 32;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 5;

    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd0;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd3;
    localparam logic [REQ_W-1:0] REQ_GET        = 4'd4;
    localparam logic [REQ_W-1:0] REQ_REPLACE    = 4'd5;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 4'd6;
    localparam logic [REQ_W-1:0] REQ_PEEK_LAST  = 4'd7;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd8;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

endpackage

`default_nettype wire

/* src/deq_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// depends on deq_pkg for its parameter defaults
`default_nettype none

module deq_ram #(
    parameter int WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/double_ended_queue_unit.sv */
// double-ended queue top level: request channel, result channel, sequencer
// depends on deq_pkg and deq_ram (element store)
//
// usage
//   requests come in on in_valid/in_stall with req_type, index and write_data;
//   every transaction on the request side gives exactly one transaction on the
//   result side with status, read_data and fill_count, in request order.
//   elements sit in one synchronous ram (one write, one read port, registered
//   read data) addressed as a ring from the head pointer.
// sequencing
//   push, replace, clear and refused requests: result registered from the
//   accepted request. pop, get and peek: ram read issued with the request,
//   read data taken into the output register in S_READ. remove at position
//   p moves each later element down by one ram read (S_SH_RD) and one ram
//   write (S_SH_WR); no new request is taken outside S_IDLE.
// reset
//   the queue comes up empty with the head at slot zero; store contents are
//   left as they are and never read before being written.
// stalls
//   a waiting result is held in the output register; one further request is
//   taken only once that register is free or being emptied.
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [deq_pkg::REQ_W-1:0]        req_type,
    input  wire logic [deq_pkg::INDEX_W-1:0]      index,
    input  wire logic [deq_pkg::PORT_DATA_W-1:0]  write_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [deq_pkg::STATUS_W-1:0]     status,
    output logic      [deq_pkg::PORT_DATA_W-1:0]  read_data,
    output logic      [deq_pkg::FILL_W-1:0]       fill_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > deq_pkg::INDEX_W) ? CNT_W : deq_pkg::INDEX_W;
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_OFF  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SH_RD = 2'd2;
    localparam logic [1:0] S_SH_WR = 2'd3;

    logic [1:0]                        state_reg, state_next;
    logic [PTR_W-1:0]                  head_reg, head_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [PTR_W-1:0]                  cur_reg, cur_next;
    logic                              out_valid_reg, out_valid_next;
    logic [deq_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [deq_pkg::PORT_DATA_W-1:0]   read_data_reg, read_data_next;
    logic [deq_pkg::FILL_W-1:0]        fill_reg, fill_next;

    logic                              ram_we;
    logic [PTR_W-1:0]                  ram_waddr;
    logic [DATA_WIDTH-1:0]             ram_wdata;
    logic                              ram_re;
    logic [PTR_W-1:0]                  ram_raddr;
    logic [DATA_WIDTH-1:0]             ram_rdata;

    logic                              in_acc;
    logic                              is_full;
    logic                              is_empty;
    logic                              idx_ok;
    logic [CMP_W-1:0]                  idx_ext;
    logic [PTR_W-1:0]                  idx_p;
    logic [PTR_W-1:0]                  back_off;
    logic [deq_pkg::STATUS_W-1:0]      req_status;
    logic                              req_done;

    function automatic logic [PTR_W-1:0] slot_at(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[PTR_W-1:0];
    endfunction

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_acc    = in_valid && !in_stall;
    assign is_full   = (count_reg == CNT_FULL);
    assign is_empty  = (count_reg == '0);
    assign idx_ext   = CMP_W'(index);
    assign idx_ok    = (idx_ext < CMP_W'(count_reg));
    assign idx_p     = idx_ext[PTR_W-1:0];
    assign back_off  = PTR_W'(count_reg - CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        read_data_next = read_data_reg;
        fill_next      = fill_reg;
        ram_we         = 1'b0;
        ram_waddr      = head_reg;
        ram_wdata      = DATA_WIDTH'(write_data);
        ram_re         = 1'b0;
        ram_raddr      = head_reg;
        req_status     = deq_pkg::STAT_OK;
        req_done       = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (req_type)
                        deq_pkg::REQ_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                req_status = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot_at(head_reg, PTR_W'(count_reg));
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        deq_pkg::REQ_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                req_status = deq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                head_next  = slot_at(head_reg, LAST_OFF);
                                ram_we     = 1'b1;
                                ram_waddr  = head_next;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        deq_pkg::REQ_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                req_status = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = slot_at(head_reg, back_off);
                                count_next = count_reg - CNT_W'(1);
                                req_done   = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        deq_pkg::REQ_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                req_status = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                head_next  = slot_at(head_reg, PTR_W'(1));
                                count_next = count_reg - CNT_W'(1);
                                req_done   = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        deq_pkg::REQ_PEEK_LAST:
                        begin
                            if (is_empty)
                            begin
                                req_status = deq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = slot_at(head_reg, back_off);
                                req_done   = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        deq_pkg::REQ_GET:
                        begin
                            if (!idx_ok)
                            begin
                                req_status = deq_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = slot_at(head_reg, idx_p);
                                req_done   = 1'b0;
                                state_next = S_READ;
                            end
                        end
                        deq_pkg::REQ_REPLACE:
                        begin
                            if (!idx_ok)
                            begin
                                req_status = deq_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = slot_at(head_reg, idx_p);
                            end
                        end
                        deq_pkg::REQ_REMOVE:
                        begin
                            if (!idx_ok)
                            begin
                                req_status = deq_pkg::STAT_RANGE;
                            end
                            else if ((idx_ext + CMP_W'(1)) < CMP_W'(count_reg))
                            begin
                                cur_next   = idx_p;
                                req_done   = 1'b0;
                                state_next = S_SH_RD;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        deq_pkg::REQ_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            req_status = deq_pkg::STAT_OK;
                        end
                    endcase

                    if (req_done)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = req_status;
                        read_data_next = '0;
                        fill_next      = deq_pkg::FILL_W'(count_next);
                    end
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                status_next    = deq_pkg::STAT_OK;
                read_data_next = deq_pkg::PORT_DATA_W'(ram_rdata);
                fill_next      = deq_pkg::FILL_W'(count_reg);
                state_next     = S_IDLE;
            end
            S_SH_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = slot_at(head_reg, cur_reg + PTR_W'(1));
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot_at(head_reg, cur_reg);
                ram_wdata = ram_rdata;
                cur_next  = cur_reg + PTR_W'(1);
                if ((CNT_W'(cur_reg) + CNT_W'(2)) < count_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    count_next     = count_reg - CNT_W'(1);
                    out_valid_next = 1'b1;
                    status_next    = deq_pkg::STAT_OK;
                    read_data_next = '0;
                    fill_next      = deq_pkg::FILL_W'(count_next);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        status_reg    <= status_next;
        read_data_reg <= read_data_next;
        fill_reg      <= fill_next;
    end

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_data  = read_data_reg;
    assign fill_count = fill_reg;

endmodule

`default_nettype wire

/* src/deq_checker.sv */
// port-level checks for the double-ended queue result channel, bound to
// double_ended_queue_unit; depends on deq_pkg for status codes and widths
`default_nettype none

module deq_checker #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [deq_pkg::STATUS_W-1:0]    status,
    input wire logic [deq_pkg::PORT_DATA_W-1:0] read_data,
    input wire logic [deq_pkg::FILL_W-1:0]      fill_count
);

    // a stalled result transaction keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(read_data) && $stable(fill_count))
    else $error("result changed while stalled");

    // refused push only when the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == deq_pkg::STAT_FULL)
            |-> fill_count == deq_pkg::FILL_W'(DEPTH))
    else $error("full status with queue not full");

    // empty status only on an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == deq_pkg::STAT_EMPTY) |-> fill_count == '0)
    else $error("empty status with elements held");

    // refused requests return no data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != deq_pkg::STAT_OK) |-> read_data == '0)
    else $error("data returned with error status");

endmodule

bind double_ended_queue_unit deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

`default_nettype wire
